FILE: rtl/nwtl_pkg.sv
package nwtl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  entry_index;
        logic        entry_enable;
        logic [31:0] key_ip;
        logic [15:0] key_port;
        logic        ip_any;
        logic        port_any;
        logic [31:0] target_ip;
        logic [15:0] target_port;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  hit_index;
        logic [31:0] out_ip;
        logic [15:0] out_port;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] key_ip;
        logic [15:0] key_port;
        logic        ip_any;
        logic        port_any;
        logic [31:0] target_ip;
        logic [15:0] target_port;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

    function automatic logic slot_hits(slot_entry_t ent, logic [31:0] ip, logic [15:0] port);
        logic ip_eq;
        logic port_eq;
        ip_eq   = (ent.key_ip == ip);
        port_eq = (ent.key_port == port);
        case ({ent.ip_any, ent.port_any})
            2'b00:   return ip_eq && port_eq;
            2'b10:   return port_eq;
            2'b01:   return ip_eq;
            default: return 1'b0;
        endcase
    endfunction

endpackage

FILE: rtl/nat_wildcard_table_lookup.sv
// Prioritised NAT table with address and port wildcards.
// Request channel (req_valid, req_stall, req): an item with func = FUNC_WRITE
// loads or clears one slot in the cycle it is accepted and gives no result;
// an item with func = FUNC_XLATE looks up the flow address and port.
// Response channel (rsp_valid, rsp_stall, rsp): one item per lookup, with the
// first matching slot in index order, or a miss with all fields zero.
// A lookup reads the entry memory one slot per cycle through its single read
// port, stopping at the first hit; the block returns to idle, ready for the
// next item, once the result has moved into the output register.
// A write leaves the block idle. req_stall is high while a lookup is in
// progress, so lookups run one at a time; the next item is taken while a
// finished result still waits in the output register.
// When rsp_stall is high the result holds in the output register, and a
// finished lookup waits until that register frees.
// Reset clears all slot valid bits, the output valid and the control state;
// the entry memory itself is not cleared, as only valid slots can match.
module nat_wildcard_table_lookup
    import nwtl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [31:0]            key_ip_reg, key_ip_next;
    logic [15:0]            key_port_reg, key_port_next;
    rsp_item_t              res_reg, res_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_reg, rsp_next;

    logic                   req_take;
    logic                   wr_in_range;
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;
    slot_entry_t            wr_entry;
    slot_entry_t            rd_entry;
    logic                   slot_match;
    logic                   last_slot;
    logic                   rsp_free;

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_take    = req_valid && !req_stall;
    assign wr_in_range = (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign ram_wr_en   = req_take && (req.func == FUNC_WRITE) && wr_in_range && req.entry_enable;

    always_comb
    begin
        wr_entry.key_ip      = req.key_ip;
        wr_entry.key_port    = req.key_port;
        wr_entry.ip_any      = req.ip_any;
        wr_entry.port_any    = req.port_any;
        wr_entry.target_ip   = req.target_ip;
        wr_entry.target_port = req.target_port;
    end

    nwtl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(req.entry_index)),
        .wr_data (wr_entry),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry   = slot_entry_t'(ram_rd_data);
    assign slot_match = slot_valid_reg[cnt_reg] &&
                        slot_hits(rd_entry, key_ip_reg, key_port_reg);
    assign last_slot  = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign ram_rd_addr = (state_reg == ST_SCAN) ? cnt_reg + IDX_W'(1) : '0;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        slot_valid_next = slot_valid_reg;
        key_ip_next     = key_ip_reg;
        key_port_next   = key_port_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (req.func == FUNC_XLATE)
                    begin
                        key_ip_next   = req.key_ip;
                        key_port_next = req.key_port;
                        cnt_next      = '0;
                        state_next    = ST_SCAN;
                    end
                    else if (wr_in_range)
                    begin
                        slot_valid_next[IDX_W'(req.entry_index)] = req.entry_enable;
                    end
                end
            end
            ST_SCAN:
            begin
                if (slot_match)
                begin
                    res_next.hit       = 1'b1;
                    res_next.hit_index = 4'(cnt_reg);
                    res_next.out_ip    = rd_entry.target_ip;
                    res_next.out_port  = rd_entry.target_port;
                    state_next         = ST_REPORT;
                end
                else if (last_slot)
                begin
                    res_next   = '0;
                    state_next = ST_REPORT;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_REPORT:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_ip_reg   <= key_ip_next;
        key_port_reg <= key_port_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.hit) |->
            (rsp_reg.hit_index == 4'd0 && rsp_reg.out_ip == 32'd0 && rsp_reg.out_port == 16'd0))
        else $error("miss result carries non-zero fields");

    a_scan_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN) |->
            (cnt_reg == IDX_W'($past(cnt_reg) + IDX_W'(1))))
        else $error("scan counter skipped a slot");

    a_report_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |->
            ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_REPORT))
        else $error("report entered without a scan");

endmodule

FILE: rtl/nwtl_ram.sv
module nwtl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: bench/nwtl_checker.sv
module nwtl_checker
    import nwtl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        fail_count,
    output int        pending,
    output int        hit_count,
    output int        miss_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        slot_live [TABLE_DEPTH];
    slot_entry_t slot_copy [TABLE_DEPTH];
    rsp_item_t   expected_xlations [$];
    rsp_item_t   want;
    logic        bad;
    int          fails;
    int          hits;
    int          misses;

    function automatic rsp_item_t predict_translation(logic [31:0] ip, logic [15:0] port);
        rsp_item_t res;
        logic      matched;
        res = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!res.hit && slot_live[i]) begin
                if (slot_copy[i].ip_any && slot_copy[i].port_any)
                    matched = 1'b0;
                else
                    matched = (slot_copy[i].ip_any || slot_copy[i].key_ip == ip) &&
                              (slot_copy[i].port_any || slot_copy[i].key_port == port);
                if (matched) begin
                    res.hit       = 1'b1;
                    res.hit_index = 4'(i);
                    res.out_ip    = slot_copy[i].target_ip;
                    res.out_port  = slot_copy[i].target_port;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_live[i] = 1'b0;
            expected_xlations.delete();
            fails  = 0;
            hits   = 0;
            misses = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_xlations.size() == 0)
                begin
                    $display("%0t: unexpected item hit=%0d index=%0d ip=%h port=%h", $time,
                             rsp.hit, rsp.hit_index, rsp.out_ip, rsp.out_port);
                    fails++;
                end
                else
                begin
                    want = expected_xlations.pop_front();
                    bad  = 1'b0;
                    if (rsp.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0d, got %0d", $time, want.hit, rsp.hit);
                        bad = 1'b1;
                    end
                    if (rsp.hit_index !== want.hit_index)
                    begin
                        $display("%0t: hit_index expected %0d, got %0d", $time,
                                 want.hit_index, rsp.hit_index);
                        bad = 1'b1;
                    end
                    if (rsp.out_ip !== want.out_ip)
                    begin
                        $display("%0t: out_ip expected %h, got %h", $time,
                                 want.out_ip, rsp.out_ip);
                        bad = 1'b1;
                    end
                    if (rsp.out_port !== want.out_port)
                    begin
                        $display("%0t: out_port expected %h, got %h", $time,
                                 want.out_port, rsp.out_port);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                    if (want.hit)
                        hits++;
                    else
                        misses++;
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req.func == FUNC_WRITE)
                begin
                    if (req.entry_index < TABLE_DEPTH)
                    begin
                        if (req.entry_enable)
                        begin
                            slot_copy[req.entry_index].key_ip      = req.key_ip;
                            slot_copy[req.entry_index].key_port    = req.key_port;
                            slot_copy[req.entry_index].ip_any      = req.ip_any;
                            slot_copy[req.entry_index].port_any    = req.port_any;
                            slot_copy[req.entry_index].target_ip   = req.target_ip;
                            slot_copy[req.entry_index].target_port = req.target_port;
                            slot_live[req.entry_index] = 1'b1;
                        end
                        else
                            slot_live[req.entry_index] = 1'b0;
                    end
                end
                else
                    expected_xlations.insert(expected_xlations.size(),
                                             predict_translation(req.key_ip, req.key_port));
            end
        end
        fail_count <= fails;
        pending    <= expected_xlations.size();
        hit_count  <= hits;
        miss_count <= misses;
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nwtl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1400;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;

    int          fails;
    int          pending;
    int          hits;
    int          misses;
    int          cycles       = 0;
    int          burst_left   = 0;
    int          writes_sent  = 0;
    int          lookups_sent = 0;
    stall_mode_t stall_mode   = STALL_NONE;
    int          stall_left   = 0;

    logic [31:0] seen_ip   [TABLE_DEPTH];
    logic [15:0] seen_port [TABLE_DEPTH];
    logic [31:0] ip_pool   [4];
    logic [15:0] port_pool [4];

    nat_wildcard_table_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    nwtl_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fails),
        .pending    (pending),
        .hit_count  (hits),
        .miss_count (misses)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(8, 80);
            rsp_stall  <= 1'b0;
        end
        else
        begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:     rsp_stall <= (stall_left[1:0] == 2'b00);
            endcase
        end
    end

    function automatic req_item_t random_item();
        req_item_t item;
        item.func         = 1'($urandom_range(0, 1));
        item.entry_index  = 4'($urandom_range(0, 15));
        item.entry_enable = 1'($urandom_range(0, 1));
        item.key_ip       = $urandom;
        item.key_port     = 16'($urandom_range(0, 65535));
        item.ip_any       = 1'($urandom_range(0, 1));
        item.port_any     = 1'($urandom_range(0, 1));
        item.target_ip    = $urandom;
        item.target_port  = 16'($urandom_range(0, 65535));
        return item;
    endfunction

    function automatic logic [31:0] pick_ip();
        return ($urandom_range(0, 2) != 0) ? ip_pool[$urandom_range(0, 3)] : $urandom;
    endfunction

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 2) != 0) ? port_pool[$urandom_range(0, 3)]
                                            : 16'($urandom_range(0, 65535));
    endfunction

    // hold the item until accepted; sometimes idle between bursts
    task automatic push_item(req_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic write_slot(int idx, logic en, logic [31:0] ip, logic [15:0] port,
                              logic ipw, logic portw, logic [31:0] tip, logic [15:0] tport);
        req_item_t item;
        item              = random_item();
        item.func         = FUNC_WRITE;
        item.entry_index  = idx[3:0];
        item.entry_enable = en;
        if (en)
        begin
            item.key_ip      = ip;
            item.key_port    = port;
            item.ip_any      = ipw;
            item.port_any    = portw;
            item.target_ip   = tip;
            item.target_port = tport;
            seen_ip[idx]     = ip;
            seen_port[idx]   = port;
        end
        writes_sent++;
        push_item(item);
    endtask

    task automatic look_up(logic [31:0] ip, logic [15:0] port);
        req_item_t item;
        item          = random_item();
        item.func     = FUNC_XLATE;
        item.key_ip   = ip;
        item.key_port = port;
        lookups_sent++;
        push_item(item);
    endtask

    initial
    begin
        int          sel;
        int          slot;
        logic [31:0] ip;
        logic [15:0] port;

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            seen_ip[i]   = '0;
            seen_port[i] = '0;
        end
        ip_pool   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001, $urandom};
        port_pool = '{16'h0000, 16'hFFFF, 16'h0050, 16'($urandom_range(0, 65535))};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        look_up(32'h0000_0000, 16'h0000);
        // at least one slot of each wildcard kind
        write_slot(0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 32'h0A00_0001, 16'h1234);
        write_slot(5, 1'b1, 32'h1111_1111, 16'h0050, 1'b1, 1'b0, 32'h0A00_0005, 16'h5555);
        write_slot(9, 1'b1, 32'hC0A8_0001, 16'h2222, 1'b0, 1'b1, 32'h0A00_0009, 16'h9999);
        write_slot(15, 1'b1, 32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        write_slot(12, 1'b1, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        look_up(32'hFFFF_FFFF, 16'hFFFF);
        look_up(32'h1234_5678, 16'h0050);
        look_up(32'hC0A8_0001, 16'h7777);
        // lower index wins
        look_up(32'hC0A8_0001, 16'h0050);
        // fully wildcarded slot never matches
        look_up(32'h0000_0000, 16'h0000);
        look_up(32'hDEAD_BEEF, 16'hBEEF);
        // clear keeps the key but drops the slot
        write_slot(5, 1'b0, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        look_up(32'h1234_5678, 16'h0050);
        look_up(32'hC0A8_0001, 16'h0050);
        write_slot(3, 1'b1, 32'hC0A8_0001, 16'h0050, 1'b0, 1'b0, 32'h5A5A_5A5A, 16'hA5A5);
        look_up(32'hC0A8_0001, 16'h0050);
        write_slot(15, 1'b1, 32'hAAAA_AAAA, 16'h5555, 1'b0, 1'b0, 32'h5555_5555, 16'hAAAA);
        look_up(32'hAAAA_AAAA, 16'h5555);
        look_up(32'hAAAA_AAAA, 16'h5554);
        look_up(32'h5555_5555, 16'hAAAA);

        while (writes_sent + lookups_sent < RANDOM_ITEMS + 20)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
            begin
                // empty the table
                for (int i = 0; i < TABLE_DEPTH; i++)
                    write_slot(i, 1'b0, $urandom, 16'($urandom_range(0, 65535)), 1'b0, 1'b0,
                               $urandom, 16'($urandom_range(0, 65535)));
            end
            else if (sel < 32)
                write_slot($urandom_range(0, 15), $urandom_range(0, 7) != 0, pick_ip(),
                           pick_port(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom, 16'($urandom_range(0, 65535)));
            else if (sel < 75)
            begin
                slot = $urandom_range(0, TABLE_DEPTH - 1);
                ip   = seen_ip[slot];
                port = seen_port[slot];
                case ($urandom_range(0, 3))
                    0:       ip = pick_ip();
                    1:       port = pick_port();
                    default: ;
                endcase
                look_up(ip, port);
            end
            else
                look_up(pick_ip(), pick_port());
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge clk);

        $display("Sent %0d table writes and %0d lookups with random idling on both sides.",
                 writes_sent, lookups_sent);
        $display("Lookups checked: %0d hits, %0d misses.", hits, misses);
        if (fails == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
